// File: hdl/ble_pkg.sv
// Shared types and codes of the bounded list engine: opcodes, status codes,
// controller states and the control word broadcast to the row of cells.
// No dependencies.
package ble_pkg;

   localparam int WORD_W = 32;

   typedef enum logic [2:0] {
      OP_APPEND     = 3'd0,
      OP_INSERT     = 3'd1,
      OP_REMOVE_AT  = 3'd2,
      OP_REMOVE_VAL = 3'd3,
      OP_FIND       = 3'd4,
      OP_SHOW       = 3'd5,
      OP_REVERSE    = 3'd6
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADPOS = 2'd2,
      ST_NONE   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_ROT  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_INSERT    = 2'd1,
      CELL_SHIFT_ENQ = 2'd2,
      CELL_ROT_RIGHT = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic              keep;
      logic [WORD_W-1:0] word;
   } cell_ctl_type;

endpackage

// File: hdl/ble_cell.sv
// One cell of the list row: holds one stored word and takes a new value from
// the broadcast control word or from its left or right neighbor.
// Depends on ble_pkg.
module ble_cell
   import ble_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CW    = 6
) (
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic [CW-1:0]     idx,
   input  logic [WORD_W-1:0] left_word,
   input  logic [WORD_W-1:0] right_word,
   output logic [WORD_W-1:0] word_q
);

   localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      case (ctl.op)
         CELL_INSERT: begin
            // Cells above the insert point move up by one place.
            if (MY_INDEX == idx) begin
               word_in = ctl.word;
            end else if (MY_INDEX > idx) begin
               word_in = left_word;
            end
         end
         CELL_SHIFT_ENQ: begin
            // The head leaves; a kept word re-enters at the end of the queue.
            if (MY_INDEX < idx) begin
               word_in = right_word;
            end else if (MY_INDEX == idx && ctl.keep) begin
               word_in = ctl.word;
            end
         end
         CELL_ROT_RIGHT: begin
            word_in = left_word;
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_q = word_ff;

endmodule

// File: hdl/bounded_list_engine_core.sv
// Bounded list engine: an ordered list of up to DEPTH signed words kept in a
// row of cells, with a sequencer that drives one command at a time.
// Depends on ble_pkg and ble_cell.
//
// Usage: one command item enters on the req_ channel (valid/ready) and yields
// a run of result items on the rsp_ channel; the last item of a run has
// rsp_last set. Opcode 7 yields no result.
// Append and insert shift the row as the item is taken and register their
// result at once; a new item is taken when the output register is free.
// Remove at, remove value, find and show rotate the first count cells
// through the head of the row, one cell per cycle unless an output stall
// holds the rotation; the next item is taken only once the last result of
// the run has gone to the output register. Reverse show rotates the whole
// row the other way and likewise takes no new item before its last result.
// Rotating results pass through one pending register and one output register;
// when the receiver stalls, the rotation waits in place and nothing is lost.
// Reset empties the list and drops any result held; the stored words
// themselves are not cleared.
module bounded_list_engine_core
   import ble_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_opcode,
   input  logic [5:0]         req_position,
   input  logic signed [31:0] req_operand_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int PW = (CW > 6) ? CW : 6;

   logic [WORD_W-1:0] cell_q [DEPTH];
   cell_ctl_type      ctl;
   logic [CW-1:0]     cell_idx;

   state_type         state_ff, state_in;
   opcode_type        op_ff, op_in;
   logic [5:0]        pos_ff, pos_in;
   logic [WORD_W-1:0] val_ff, val_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [IW-1:0]     step_ff, step_in;
   logic [CW-1:0]     kept_ff, kept_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [WORD_W-1:0] pend_value_ff, pend_value_in;
   logic [WORD_W-1:0] gone_ff, gone_in;
   logic [CW-1:0]     count_ff, count_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff;
   status_type        rsp_status_ff;
   logic              rsp_last_ff;

   logic              out_load;
   logic [WORD_W-1:0] out_value;
   status_type        out_status;
   logic              out_last;

   logic              out_free;
   logic [WORD_W-1:0] head;
   logic [WORD_W-1:0] tail;
   logic              keep;
   logic              emit;
   logic [WORD_W-1:0] emit_value;
   logic              full;
   logic [PW-1:0]     req_pos_ext;
   logic [PW-1:0]     count_ext;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         localparam int LEFT  = (gi + DEPTH - 1) % DEPTH;
         localparam int RIGHT = (gi < DEPTH - 1) ? gi + 1 : gi;
         ble_cell #(
            .INDEX (gi),
            .CW    (CW)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .idx        (cell_idx),
            .left_word  (cell_q[LEFT]),
            .right_word (cell_q[RIGHT]),
            .word_q     (cell_q[gi])
         );
      end
   endgenerate

   assign head        = cell_q[0];
   assign tail        = cell_q[DEPTH-1];
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE) && out_free;
   assign full        = (count_ff == CW'(DEPTH));
   assign req_pos_ext = PW'(req_position);
   assign count_ext   = PW'(count_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      n_in          = n_ff;
      step_in       = step_ff;
      kept_in       = kept_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      gone_in       = gone_ff;
      count_in      = count_ff;
      out_load      = 1'b0;
      out_value     = '0;
      out_status    = ST_OK;
      out_last      = 1'b0;
      ctl.op        = CELL_HOLD;
      ctl.keep      = 1'b0;
      ctl.word      = val_ff;
      cell_idx      = '0;
      keep          = 1'b1;
      emit          = 1'b0;
      emit_value    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in         = opcode_type'(req_opcode);
               pos_in        = req_position;
               val_in        = req_operand_value;
               n_in          = count_ff;
               step_in       = '0;
               kept_in       = '0;
               pend_valid_in = 1'b0;
               case (opcode_type'(req_opcode))
                  OP_APPEND, OP_INSERT: begin
                     out_load = 1'b1;
                     out_last = 1'b1;
                     if (full) begin
                        out_status = ST_FULL;
                     end else if (opcode_type'(req_opcode) == OP_INSERT &&
                                  req_pos_ext > count_ext) begin
                        out_status = ST_BADPOS;
                     end else begin
                        ctl.op    = CELL_INSERT;
                        ctl.word  = req_operand_value;
                        cell_idx  = (opcode_type'(req_opcode) == OP_APPEND) ?
                                    count_ff : CW'(req_position);
                        count_in  = count_ff + CW'(1);
                        out_value = req_operand_value;
                     end
                  end
                  OP_REMOVE_AT: begin
                     if (req_pos_ext >= count_ext) begin
                        out_load   = 1'b1;
                        out_last   = 1'b1;
                        out_status = ST_BADPOS;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_REMOVE_VAL: begin
                     if (count_ff == '0) begin
                        out_load = 1'b1;
                        out_last = 1'b1;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_FIND, OP_SHOW: begin
                     if (count_ff == '0) begin
                        out_load   = 1'b1;
                        out_last   = 1'b1;
                        out_status = ST_NONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_REVERSE: begin
                     if (count_ff == '0) begin
                        out_load   = 1'b1;
                        out_last   = 1'b1;
                        out_status = ST_NONE;
                     end else begin
                        state_in = S_ROT;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // The head cell holds the word at original index step_ff.
            case (op_ff)
               OP_REMOVE_AT:  keep = (PW'(step_ff) != PW'(pos_ff));
               OP_REMOVE_VAL: keep = (head != val_ff);
               default:       keep = 1'b1;
            endcase
            case (op_ff)
               OP_FIND: begin
                  emit       = (head == val_ff);
                  emit_value = WORD_W'(step_ff);
               end
               OP_SHOW: begin
                  emit       = 1'b1;
                  emit_value = head;
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
            if (!emit || !pend_valid_ff || out_free) begin
               ctl.op   = CELL_SHIFT_ENQ;
               ctl.keep = keep;
               ctl.word = head;
               // End of the queue: unvisited words, then the words kept so far.
               cell_idx = n_ff - CW'(1) - CW'(step_ff) + kept_ff;
               kept_in  = kept_ff + CW'(keep);
               if (emit) begin
                  if (pend_valid_ff) begin
                     out_load  = 1'b1;
                     out_value = pend_value_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_value_in = emit_value;
               end
               if (!keep) begin
                  gone_in = head;
               end
               if (CW'(step_ff) == n_ff - CW'(1)) begin
                  state_in = S_DONE;
                  count_in = kept_ff + CW'(keep);
               end else begin
                  step_in = step_ff + IW'(1);
               end
            end
         end

         S_ROT: begin
            // The tail cell holds the word at original index DEPTH-1-step_ff.
            emit       = (CW'(DEPTH - 1) - CW'(step_ff)) < n_ff;
            emit_value = tail;
            if (!emit || !pend_valid_ff || out_free) begin
               ctl.op = CELL_ROT_RIGHT;
               if (emit) begin
                  if (pend_valid_ff) begin
                     out_load  = 1'b1;
                     out_value = pend_value_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_value_in = emit_value;
               end
               if (step_ff == IW'(DEPTH - 1)) begin
                  state_in = S_DONE;
               end else begin
                  step_in = step_ff + IW'(1);
               end
            end
         end

         S_DONE: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_last      = 1'b1;
               state_in      = S_IDLE;
               pend_valid_in = 1'b0;
               case (op_ff)
                  OP_REMOVE_AT: begin
                     out_value = gone_ff;
                  end
                  OP_REMOVE_VAL: begin
                     out_value = WORD_W'(n_ff - kept_ff);
                  end
                  default: begin
                     if (pend_valid_ff) begin
                        out_value = pend_value_ff;
                     end else begin
                        out_status = ST_NONE;
                     end
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      n_ff          <= n_in;
      step_ff       <= step_in;
      kept_ff       <= kept_in;
      pend_value_ff <= pend_value_in;
      gone_ff       <= gone_in;
      if (out_load) begin
         rsp_value_ff  <= out_value;
         rsp_status_ff <= out_status;
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

   // The list never grows beyond its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count exceeds depth");

   // No result waits in the pending register once the sequencer is idle.
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_valid_ff)
      else $error("pending result left behind in idle");

   // A scan never visits a cell beyond the count it started with.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> CW'(step_ff) < n_ff)
      else $error("scan step beyond list length");

   // Find and show leave the list length untouched.
   a_scan_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && (op_ff == OP_FIND || op_ff == OP_SHOW))
      |=> count_ff == $past(count_ff))
      else $error("read-only scan changed the count");

   // A finished run is delivered before a new item is taken.
   a_done_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> rsp_valid_ff && rsp_last_ff)
      else $error("final result of run not delivered");

endmodule
